>>> hdl/gae_pkg.sv
// Shared types and codes for the GAE advantage scan block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package gae_pkg;

    typedef struct packed {
        logic signed [31:0] reward;
        logic        [1:0]  terminal_kind;
        logic signed [31:0] value_pred;
        logic signed [31:0] trunc_value;
        logic               first_item;
    } t_in;

    typedef struct packed {
        logic signed [31:0] advantage;
        logic signed [31:0] discounted_return;
        logic signed [31:0] target_value;
    } t_out;

    // terminal kinds; the undefined code behaves as ongoing
    localparam logic [1:0] KIND_ONGOING = 2'd0;
    localparam logic [1:0] KIND_ENDED   = 2'd1;
    localparam logic [1:0] KIND_TRUNC   = 2'd2;
    localparam logic [1:0] KIND_UNDEF   = 2'd3;

    // datapath step codes, one per cycle of the sequence while the output is not stalled
    localparam logic [2:0] STEP_NONE = 3'd0;
    localparam logic [2:0] STEP_GL   = 3'd1;   // discount * trace_decay
    localparam logic [2:0] STEP_RS   = 3'd2;   // reward * inverse_std
    localparam logic [2:0] STEP_CA   = 3'd3;   // carried advantage * gl
    localparam logic [2:0] STEP_NX   = 3'd4;   // bootstrap value * discount
    localparam logic [2:0] STEP_CR   = 3'd5;   // carried return * discount
    localparam logic [2:0] STEP_FIN  = 3'd6;   // final sums, load output

    typedef struct packed {
        logic       capture;
        logic [2:0] step;
    } t_cmd;

    localparam logic [2:0] CFG_DISCOUNT    = 3'd0;
    localparam logic [2:0] CFG_TRACE_DECAY = 3'd1;
    localparam logic [2:0] CFG_STD_ON      = 3'd2;
    localparam logic [2:0] CFG_INV_STD     = 3'd3;
    localparam logic [2:0] CFG_CLIP        = 3'd4;

    localparam int CFG_W = 31;

endpackage

`default_nettype wire

>>> hdl/gae_ctrl.sv
// Sequencer for the GAE scan: walks one item through the multiply steps.
// Depends on gae_pkg for the command struct and step codes.
`timescale 1ns / 1ps
`default_nettype none

module gae_ctrl import gae_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GL   = 3'd1;
    localparam logic [2:0] S_RS   = 3'd2;
    localparam logic [2:0] S_CA   = 3'd3;
    localparam logic [2:0] S_NX   = 3'd4;
    localparam logic [2:0] S_CR   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.step   = STEP_NONE;
        n_out_valid  = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_GL;
                end
            end
            S_GL: begin
                o_cmd.step = STEP_GL;
                n_state    = S_RS;
            end
            S_RS: begin
                o_cmd.step = STEP_RS;
                n_state    = S_CA;
            end
            S_CA: begin
                o_cmd.step = STEP_CA;
                n_state    = S_NX;
            end
            S_NX: begin
                o_cmd.step = STEP_NX;
                n_state    = S_CR;
            end
            S_CR: begin
                o_cmd.step = STEP_CR;
                n_state    = S_FIN;
            end
            S_FIN: begin
                // hold here until the output register can take the item
                if (w_slot_free) begin
                    o_cmd.step  = STEP_FIN;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

>>> hdl/gae_datapath.sv
// Datapath for the GAE scan: config registers, one shared 32x25 multiplier,
// rounding, saturation, carried state and the output register. Uses gae_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gae_datapath import gae_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [2:0]       i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    input  wire t_cmd             i_cmd,
    input  wire t_in              i_in_data,
    output t_out                  o_out_data
);

    localparam logic signed [43:0] S32_MAX = 44'sd2147483647;
    localparam logic signed [43:0] S32_MIN = -44'sd2147483648;

    // round to nearest, ties up: (p + 2^15) >> 16, floor shift
    function automatic logic signed [40:0] rnd(input logic signed [56:0] p);
        logic signed [57:0] t;
        t = 58'(p) + 58'sd32768;
        return $signed(t[56:16]);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
        logic signed [31:0] res;
        if (v > S32_MAX) begin
            res = 32'sh7fffffff;
        end else if (v < S32_MIN) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // configuration
    logic [16:0]      r_discount;
    logic [16:0]      r_trace_decay;
    logic             r_std_on;
    logic [23:0]      r_inv_std;
    logic [30:0]      r_clip;

    // carried state
    logic signed [31:0] r_carried_adv;
    logic signed [31:0] r_carried_ret;
    logic signed [31:0] r_later_value;

    // per-item working registers
    t_in                r_in;
    logic signed [56:0] r_prod;
    logic [17:0]        r_gl;
    logic signed [31:0] r_scaled;
    logic signed [43:0] r_acc;
    logic signed [31:0] r_adv;
    t_out               r_out;

    logic               w_ended, w_trunc, w_cut;
    logic signed [31:0] w_next;
    logic signed [31:0] w_ma;
    logic        [23:0] w_mf;
    logic signed [56:0] w_prod;
    logic signed [40:0] w_rnd;
    logic signed [40:0] w_clipped;
    logic signed [40:0] w_clip_pos;
    logic signed [31:0] w_ret;

    assign w_ended = (r_in.terminal_kind == KIND_ENDED);
    assign w_trunc = (r_in.terminal_kind == KIND_TRUNC);
    // a non-truncated first item bootstraps from zero and cuts like a truncation
    assign w_cut   = w_ended || w_trunc || r_in.first_item;

    always_comb begin
        if (w_trunc) begin
            w_next = r_in.trunc_value;
        end else if (r_in.first_item) begin
            w_next = '0;
        end else begin
            w_next = r_later_value;
        end
    end

    always_comb begin
        w_ma = '0;
        w_mf = '0;
        case (i_cmd.step)
            STEP_GL: begin
                w_ma = $signed({15'd0, r_discount});
                w_mf = {7'd0, r_trace_decay};
            end
            STEP_RS: begin
                w_ma = r_in.reward;
                w_mf = r_inv_std;
            end
            STEP_CA: begin
                w_ma = r_carried_adv;
                w_mf = {6'd0, r_gl};
            end
            STEP_NX: begin
                w_ma = w_next;
                w_mf = {7'd0, r_discount};
            end
            STEP_CR: begin
                w_ma = r_carried_ret;
                w_mf = {7'd0, r_discount};
            end
            default: begin
                w_ma = '0;
                w_mf = '0;
            end
        endcase
    end

    assign w_prod = w_ma * $signed({1'b0, w_mf});
    assign w_rnd  = rnd(r_prod);

    // clamp the scaled reward to +-clip_limit when clipping is on
    assign w_clip_pos = $signed({10'd0, r_clip});
    always_comb begin
        w_clipped = w_rnd;
        if (r_clip != '0) begin
            if (w_rnd > w_clip_pos) begin
                w_clipped = w_clip_pos;
            end else if (w_rnd < -w_clip_pos) begin
                w_clipped = -w_clip_pos;
            end
        end
    end

    assign w_ret = sat32(44'(r_in.reward) + (w_cut ? 44'sd0 : 44'(w_rnd)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_discount    <= 17'd65208;
            r_trace_decay <= 17'd62259;
            r_std_on      <= 1'b0;
            r_inv_std     <= 24'd65536;
            r_clip        <= '0;
            r_carried_adv <= '0;
            r_carried_ret <= '0;
            r_later_value <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DISCOUNT:    r_discount    <= i_cfg_wdata[16:0];
                    CFG_TRACE_DECAY: r_trace_decay <= i_cfg_wdata[16:0];
                    CFG_STD_ON:      r_std_on      <= i_cfg_wdata[0];
                    CFG_INV_STD:     r_inv_std     <= i_cfg_wdata[23:0];
                    CFG_CLIP:        r_clip        <= i_cfg_wdata[30:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.step == STEP_FIN) begin
                r_carried_adv <= r_adv;
                r_carried_ret <= w_ret;
                r_later_value <= r_in.value_pred;
            end
        end
    end

    // payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_data;
        end
        if (i_cmd.step inside {STEP_GL, STEP_RS, STEP_CA, STEP_NX, STEP_CR}) begin
            r_prod <= w_prod;
        end
        // each step after the first also retires the product of the step before it
        case (i_cmd.step)
            STEP_RS: begin
                r_gl <= w_rnd[17:0];
            end
            STEP_CA: begin
                r_scaled <= r_std_on ? sat32(44'(w_clipped)) : r_in.reward;
            end
            STEP_NX: begin
                r_acc <= 44'(r_scaled) - 44'(r_in.value_pred)
                       + (w_cut ? 44'sd0 : 44'(w_rnd));
            end
            STEP_CR: begin
                r_adv <= sat32(r_acc + (w_ended ? 44'sd0 : 44'(w_rnd)));
            end
            STEP_FIN: begin
                r_out.advantage         <= r_adv;
                r_out.discounted_return <= w_ret;
                r_out.target_value      <= sat32(44'(r_in.value_pred) + 44'(r_adv));
            end
            default: begin
            end
        endcase
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

>>> hdl/gae_advantage_scan_top.sv
// Top level of the GAE advantage scan: sequencer plus datapath.
// Depends on gae_pkg, gae_ctrl and gae_datapath.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+----------------------------------
//  input     | i_in_valid / o_in_ready   | i_in_data  (t_in)
//  output    | o_out_valid / i_out_ready | o_out_data (t_out)
//  config    | i_cfg_we                  | i_cfg_idx, i_cfg_wdata
//
// An item passes through the accept cycle, five steps on one shared 32x25
// multiplier (gl, scaled reward, carried advantage, bootstrap, carried
// return) and a final-sum step. The result is registered by the final-sum
// step; the next item is accepted only after that step, back in idle.
// A stalled output holds the sequence in its last step until the output
// register frees; the input side is not ready meanwhile.
// Synchronous active-low reset clears the carried state and restores the
// register defaults.
`timescale 1ns / 1ps
`default_nettype none

module gae_advantage_scan_top import gae_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in              i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out                  o_out_data,
    input  wire logic             i_cfg_we,
    input  wire logic [2:0]       i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_wdata
);

    t_cmd w_cmd;

    gae_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    gae_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> bench/tb_gae_advantage_scan_top.sv
// Testbench for the GAE advantage scan block: directed steps, then random episodes.
// A scoreboard predicts every result and checks each output item in order.
// Depends on gae_pkg and gae_advantage_scan_top.
`timescale 1ns / 1ps

module tb_gae_advantage_scan_top import gae_pkg::*;;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    localparam int CYCLE_LIMIT     = 800000;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int SETTLE_CYCLES   = 12;
    localparam int MAX_REPORTS     = 10;

    class advantage_scoreboard;
        longint discount, trace_decay, std_on, inv_std, clip;
        longint adv_carry, ret_carry, next_value;
        t_out   pending_outputs[$];
        int     failures;
        int     results_seen;

        function new();
            discount    = 65208;
            trace_decay = 62259;
            std_on      = 0;
            inv_std     = 65536;
            clip        = 0;
            adv_carry   = 0;
            ret_carry   = 0;
            next_value  = 0;
            failures    = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_DISCOUNT:    discount    = longint'(val[16:0]);
                CFG_TRACE_DECAY: trace_decay = longint'(val[16:0]);
                CFG_STD_ON:      std_on      = longint'(val[0]);
                CFG_INV_STD:     inv_std     = longint'(val[23:0]);
                CFG_CLIP:        clip        = longint'(val[30:0]);
                default: ;
            endcase
        endfunction

        // round to nearest, ties toward +inf
        function longint round16(longint p);
            return (p + 64'sd32768) >>> 16;
        endfunction

        function longint scale(longint a, longint f);
            return round16(a * f);
        endfunction

        function logic signed [31:0] sat32(longint v);
            if (v > 64'sd2147483647)
                return Q_MAX;
            if (v < -64'sd2147483648)
                return Q_MIN;
            return v[31:0];
        endfunction

        function t_out predict_step(t_in s);
            longint rw, vp, boot, r, adv, ret, gl;
            bit     ended, trunc;
            t_out   o;
            rw    = longint'(s.reward);
            vp    = longint'(s.value_pred);
            ended = (s.terminal_kind == KIND_ENDED);
            trunc = (s.terminal_kind == KIND_TRUNC);
            // newest step of a buffer bootstraps from zero and cuts the chain
            if (trunc) begin
                boot = longint'(s.trunc_value);
            end else if (s.first_item) begin
                boot  = 0;
                trunc = 1;
            end else begin
                boot = next_value;
            end
            r = rw;
            if (std_on != 0) begin
                r = scale(rw, inv_std);
                if (clip != 0) begin
                    if (r > clip)
                        r = clip;
                    if (r < -clip)
                        r = -clip;
                end
                r = longint'(sat32(r));
            end
            if (!ended)
                r += scale(boot, discount);
            adv = r - vp;
            gl  = round16(discount * trace_decay);
            ret = rw;
            if (!ended && !trunc) begin
                adv += scale(adv_carry, gl);
                ret += scale(ret_carry, discount);
            end
            o.advantage         = sat32(adv);
            o.discounted_return = sat32(ret);
            o.target_value      = sat32(vp + longint'(o.advantage));
            adv_carry  = longint'(o.advantage);
            ret_carry  = longint'(o.discounted_return);
            next_value = vp;
            return o;
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("ERROR: %s", msg);
        endfunction

        function void accept_step(t_in s);
            pending_outputs.push_back(predict_step(s));
        endfunction

        function void compare_field(string name, logic signed [31:0] exp_v,
                                    logic signed [31:0] got_v);
            if (exp_v !== got_v)
                note_failure($sformatf("result %0d %s: expected %0d, got %0d",
                                       results_seen, name, exp_v, got_v));
        endfunction

        function void check_result(t_out got);
            t_out exp_o;
            if (pending_outputs.size() == 0) begin
                note_failure($sformatf("result %0d arrived with none pending", results_seen));
            end else begin
                exp_o = pending_outputs.pop_front();
                compare_field("advantage", exp_o.advantage, got.advantage);
                compare_field("discounted_return", exp_o.discounted_return,
                              got.discounted_return);
                compare_field("target_value", exp_o.target_value, got.target_value);
            end
            results_seen++;
        endfunction

        function void close_out();
            if (pending_outputs.size() != 0)
                note_failure($sformatf("%0d results never arrived", pending_outputs.size()));
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    t_in              in_data;
    logic             out_valid;
    logic             out_ready;
    t_out             out_data;
    logic             cfg_we;
    logic [2:0]       cfg_idx;
    logic [CFG_W-1:0] cfg_wdata;
    bit               idle_on;
    int               stall_left;

    advantage_scoreboard sb = new();

    gae_advantage_scan_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAIL");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if (in_valid && in_ready)
                sb.accept_step(in_data);
            if (cfg_we)
                sb.write_reg(cfg_idx, cfg_wdata);
        end
    end

    initial begin
        out_ready  = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                out_ready = 1'b0;
                stall_left--;
            end else begin
                out_ready = 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    function automatic logic signed [31:0] rand_q16();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            1, 2, 3: return $urandom();
            default: return $urandom_range(0, 1 << 19) - (1 << 18);
        endcase
    endfunction

    function automatic logic [1:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return KIND_ONGOING;
        if (r < 88)
            return KIND_ENDED;
        if (r < 95)
            return KIND_TRUNC;
        return KIND_UNDEF;
    endfunction

    function automatic logic [CFG_W-1:0] pick_factor();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 65536;
            2: return 131071;
            3: return CFG_W'($urandom_range(55000, 65536));
            4: return CFG_W'($urandom_range(0, 131071));
            default: return CFG_W'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_inv_std();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 16777215;
            2: return 65536;
            3: return CFG_W'($urandom_range(16384, 262144));
            default: return CFG_W'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_clip();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 1;
            2: return 31'h7FFFFFFF;
            3: return CFG_W'($urandom_range(1, 1 << 20));
            default: return CFG_W'($urandom());
        endcase
    endfunction

    function automatic t_in make_step(logic signed [31:0] reward, logic [1:0] kind,
                                      logic signed [31:0] vpred,
                                      logic signed [31:0] tval, logic first);
        t_in s;
        s.reward        = reward;
        s.terminal_kind = kind;
        s.value_pred    = vpred;
        s.trunc_value   = tval;
        s.first_item    = first;
        return s;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_step(input t_in s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = s;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (sb.pending_outputs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = val;
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] disc, input logic [CFG_W-1:0] lam,
                                  input logic [CFG_W-1:0] std_on,
                                  input logic [CFG_W-1:0] inv, input logic [CFG_W-1:0] clip);
        logic [2:0] spare_idx;
        wait_drained();
        write_reg(CFG_DISCOUNT, disc);
        write_reg(CFG_TRACE_DECAY, lam);
        write_reg(CFG_STD_ON, std_on);
        write_reg(CFG_INV_STD, inv);
        write_reg(CFG_CLIP, clip);
        // writes to unused indexes must leave everything alone
        if ($urandom_range(0, 1) == 0) begin
            spare_idx = 3'($urandom_range(CFG_CLIP + 1, 7));
            write_reg(spare_idx, CFG_W'($urandom()));
        end
        cfg_we = 1'b0;
    endtask

    initial begin
        int   phase;
        int   count;
        int   ep_len;
        int   k;
        t_in  s;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_idx   = '0;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        idle_on   = 1'b1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: chain behavior and terminal kinds
        send_step(make_step(3 * Q_ONE, KIND_ONGOING, Q_ONE, Q_MAX, 1'b0));
        send_step(make_step(32'sh0001_8000, KIND_ONGOING, -Q_ONE, 32'sd0, 1'b1));
        send_step(make_step(2 * Q_ONE, KIND_ONGOING, 5 * Q_ONE, 32'sd0, 1'b0));
        send_step(make_step(-Q_ONE, KIND_ENDED, 2 * Q_ONE, Q_MAX, 1'b0));
        send_step(make_step(Q_ONE, KIND_TRUNC, -3 * Q_ONE, Q_MAX, 1'b0));
        send_step(make_step(Q_ONE, KIND_TRUNC, Q_ONE, Q_MIN, 1'b0));
        send_step(make_step(4 * Q_ONE, KIND_UNDEF, -Q_ONE, Q_MIN, 1'b0));
        send_step(make_step(Q_MAX, KIND_ONGOING, Q_MIN, Q_MAX, 1'b0));
        send_step(make_step(Q_MIN, KIND_ONGOING, Q_MAX, Q_MIN, 1'b0));
        send_step(make_step(Q_ONE, KIND_TRUNC, 32'sd0, Q_MAX, 1'b1));
        send_step(make_step(Q_MAX, KIND_ENDED, Q_MIN, Q_MAX, 1'b1));
        send_step(make_step(Q_MAX, KIND_ONGOING, Q_MAX, Q_MAX, 1'b0));
        send_step(make_step(-32'sd1, KIND_UNDEF, -32'sd1, -32'sd1, 1'b1));

        // scaled reward, clipped and then unclipped
        apply_settings(65208, 62259, 1, 16777215, 131072);
        send_step(make_step(Q_MAX, KIND_ONGOING, 32'sd0, 32'sd0, 1'b1));
        send_step(make_step(Q_MIN, KIND_ONGOING, Q_ONE, 32'sd0, 1'b0));
        send_step(make_step(32'sh0000_8000, KIND_ONGOING, -Q_ONE, 32'sd0, 1'b0));
        apply_settings(65208, 62259, 1, 16777215, 0);
        send_step(make_step(Q_MAX, KIND_ONGOING, 32'sd0, 32'sd0, 1'b0));
        send_step(make_step(Q_MIN, KIND_TRUNC, Q_MIN, Q_MIN, 1'b0));
        send_step(make_step(32'sd1, KIND_ONGOING, 32'sd0, 32'sd0, 1'b0));

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: apply_settings(65536, 65536, 0, 65536, 0);
                1: apply_settings(0, 0, 1, 0, 0);
                2: apply_settings(131071, 131071, 1, 16777215, 31'h7FFFFFFF);
                3: apply_settings(65208, 62259, 1, 16777215, 1);
                default: apply_settings(pick_factor(), pick_factor(), CFG_W'($urandom()),
                                        pick_inv_std(), pick_clip());
            endcase
            idle_on = (phase % 4 != 1);
            count = 0;
            while (count < ITEMS_PER_PHASE) begin
                ep_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 20);
                for (k = 0; k < ep_len && count < ITEMS_PER_PHASE; k++) begin
                    s.reward        = rand_q16();
                    s.value_pred    = rand_q16();
                    s.trunc_value   = rand_q16();
                    s.terminal_kind = pick_kind();
                    // most episodes open with the buffer's newest step
                    s.first_item    = (k == 0) ? ($urandom_range(0, 9) != 0)
                                               : ($urandom_range(0, 49) == 0);
                    send_step(s);
                    count++;
                    if ($urandom_range(0, 99) == 0)
                        wait_drained();
                end
            end
        end

        wait_drained();
        sb.close_out();
        if (sb.failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
